[rtl/sbm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types, constants and the lit-fraction table builder for the stereo
// bar meter.
// ----------------------------------------------------------------------------
package sbm_pkg;

  localparam int MAX_SEGMENTS = 32;
  localparam int TABLE_DEPTH  = 600;

  localparam int SEG_W    = $clog2(MAX_SEGMENTS);
  localparam int CNT_W    = $clog2(MAX_SEGMENTS + 1);
  localparam int IDX_W    = $clog2(TABLE_DEPTH);
  localparam int ROM_W    = 17;
  localparam int LEVEL_W  = 16;
  localparam int NSEG_W   = 6;
  localparam int FADE_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR = -16'sd10214;
  localparam logic signed [LEVEL_W:0]   DECAY_STEP  = 17'sd512;
  localparam logic signed [LEVEL_W:0]   LEVEL_MIN   = -17'sd32768;
  localparam logic [71:0]               EXP_STEP    = 72'd4252231657;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_DECAY = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_SEGMENTS = 2'd0,
    REG_FADE_STEPS   = 2'd1
  } reg_index_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_INDEX,
    B_ROM,
    B_SCALE,
    B_WALK
  } back_state_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] left;
    logic signed [LEVEL_W-1:0] right;
  } level_pair_t;

  typedef struct packed {
    logic                  full;
    logic                  empty;
  } q_stat_t;

  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef logic [TABLE_DEPTH-1:0][ROM_W-1:0] rom_t;

  // exp(-i/100) in Q1.16, stepped in Q1.32 with rounding
  function automatic rom_t build_rom();
    logic [71:0] v;
    rom_t        r;
    v = 72'd1 << 32;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      r[i] = ROM_W'((v + 72'd32768) >> 16);
      v    = (v * EXP_STEP + (72'd1 << 31)) >> 32;
    end
    return r;
  endfunction

  // clamp to floor, index = floor(-level * 15 / 256), limited to table
  function automatic logic [IDX_W-1:0] level_index(logic signed [LEVEL_W-1:0] lvl);
    logic signed [LEVEL_W-1:0] c;
    logic [LEVEL_W-1:0]        mag;
    logic [LEVEL_W+3:0]        prod;
    logic [11:0]               q;
    c    = (lvl < LEVEL_FLOOR) ? LEVEL_FLOOR : lvl;
    mag  = LEVEL_W'(-c);
    prod = ({4'b0, mag} << 4) - {4'b0, mag};
    q    = prod[LEVEL_W+3:8];
    if (c >= 0) begin
      q = '0;
    end
    if (int'(q) > TABLE_DEPTH - 1) begin
      q = 12'(TABLE_DEPTH - 1);
    end
    return IDX_W'(q);
  endfunction

endpackage
`default_nettype wire

[rtl/sbm_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_front
// Input side: holds the stored channel levels, applies a load or a decay
// tick on each transfer and queues the resulting level pair for rendering.
// ----------------------------------------------------------------------------
module sbm_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic signed [sbm_pkg::LEVEL_W-1:0] level_left,
  input  logic signed [sbm_pkg::LEVEL_W-1:0] level_right,
  input  sbm_pkg::q_stat_t                  q_stat,
  output logic                              push,
  output sbm_pkg::level_pair_t              push_data
);
  import sbm_pkg::*;

  logic signed [LEVEL_W-1:0] lvl_l;
  logic signed [LEVEL_W-1:0] lvl_r;

  function automatic logic signed [LEVEL_W-1:0] decay(logic signed [LEVEL_W-1:0] l);
    logic signed [LEVEL_W:0] v;
    v = {l[LEVEL_W-1], l} - DECAY_STEP;
    if (v < LEVEL_MIN) begin
      v = LEVEL_MIN;
    end
    return v[LEVEL_W-1:0];
  endfunction

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    if (opcode_t'(opcode) == OP_LOAD) begin
      push_data.left  = level_left;
      push_data.right = level_right;
    end else begin
      push_data.left  = decay(lvl_l);
      push_data.right = decay(lvl_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_l <= '0;
      lvl_r <= '0;
    end else if (push) begin
      lvl_l <= push_data.left;
      lvl_r <= push_data.right;
    end
  end

endmodule
`default_nettype wire

[rtl/sbm_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_queue
// Two-entry queue of level pairs between the input side and the renderer.
// ----------------------------------------------------------------------------
module sbm_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sbm_pkg::level_pair_t push_data,
  input  logic                 pop,
  output sbm_pkg::level_pair_t head,
  output sbm_pkg::q_stat_t     q_stat
);
  import sbm_pkg::*;

  level_pair_t entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign head         = entry[rd_ptr];
  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_stat.empty |-> !pop) else $error("pop from empty queue");

endmodule
`default_nettype wire

[rtl/sbm_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_back
// Renderer: turns a queued level pair into lit counts through the table,
// then walks the fade counter memory one segment per cycle unless stalled.
// ----------------------------------------------------------------------------
module sbm_back (
  input  logic                            clk,
  input  logic                            rst,
  input  sbm_pkg::cfg_wr_t                cfg,
  input  sbm_pkg::q_stat_t                q_stat,
  input  sbm_pkg::level_pair_t            head,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            channel,
  output logic [sbm_pkg::SEG_W-1:0]       segment,
  output logic                            lit,
  output logic [sbm_pkg::FADE_W-1:0]      fade_step,
  output logic                            all_faded,
  output logic                            last
);
  import sbm_pkg::*;

  localparam rom_t LIT_ROM = build_rom();

  back_state_t state;
  back_state_t state_next;

  logic [NSEG_W-1:0]  num_seg;
  logic [FADE_W-1:0]  fade_steps;
  logic [CNT_W-1:0]   n_eff;
  logic [FADE_W-1:0]  reload;

  logic               chan_i;
  logic [IDX_W-1:0]   idx_q;
  logic [ROM_W-1:0]   rom_q;
  logic [CNT_W+ROM_W-1:0] scaled;
  logic [CNT_W-1:0]   lit_cnt [2];

  logic [FADE_W-1:0]  fade_mem [2*MAX_SEGMENTS];
  logic [2*MAX_SEGMENTS-1:0] fvalid;

  logic               iss_active;
  logic               iss_chan;
  logic [SEG_W-1:0]   iss_seg;
  logic               seg_last;
  logic               issue;
  logic               advance;

  logic               s1_valid;
  logic               s1_chan;
  logic [SEG_W-1:0]   s1_seg;
  logic               s1_last;
  logic [FADE_W-1:0]  rd_q;
  logic               rd_vld;
  logic [FADE_W-1:0]  cur_cnt;
  logic               s1_lit;
  logic [FADE_W-1:0]  new_cnt;
  logic               wr;
  logic               af;
  logic               af_new;

  always_comb begin
    if (num_seg == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(num_seg) > MAX_SEGMENTS) begin
      n_eff = CNT_W'(MAX_SEGMENTS);
    end else begin
      n_eff = CNT_W'(num_seg);
    end
  end

  assign reload   = (fade_steps != '0) ? fade_steps - FADE_W'(1) : '0;
  assign scaled   = n_eff * rom_q;
  assign advance  = !out_valid || out_ready;
  assign issue    = (state == B_WALK) && iss_active && advance;
  assign seg_last = (CNT_W'(iss_seg) == n_eff - CNT_W'(1));
  assign wr       = (state == B_WALK) && s1_valid && advance;
  assign pop      = wr && s1_last;

  assign cur_cnt  = rd_vld ? rd_q : '0;
  assign s1_lit   = (CNT_W'(s1_seg) < lit_cnt[s1_chan]);
  assign new_cnt  = s1_lit ? reload : ((cur_cnt != '0) ? cur_cnt - FADE_W'(1) : '0);
  assign af_new   = af && !s1_lit && (new_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_stat.empty) begin
          state_next = B_INDEX;
        end
      end
      B_INDEX: state_next = B_ROM;
      B_ROM:   state_next = B_SCALE;
      B_SCALE: state_next = chan_i ? B_WALK : B_INDEX;
      B_WALK: begin
        if (pop) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      num_seg    <= NSEG_W'(16);
      fade_steps <= FADE_W'(10);
      fvalid     <= '0;
      iss_active <= 1'b0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.en) begin
        unique case (cfg.index)
          REG_NUM_SEGMENTS: begin
            num_seg <= cfg.data[NSEG_W-1:0];
            fvalid  <= '0;
          end
          REG_FADE_STEPS: fade_steps <= cfg.data;
          default: ;
        endcase
      end
      if (wr) begin
        fvalid[{s1_chan, s1_seg}] <= 1'b1;
      end
      if (state == B_SCALE && chan_i) begin
        iss_active <= 1'b1;
      end else if (issue && seg_last && iss_chan) begin
        iss_active <= 1'b0;
      end
      if (advance) begin
        s1_valid <= issue;
      end
      if (wr) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == B_IDLE) begin
      chan_i <= 1'b0;
    end
    if (state == B_INDEX) begin
      idx_q <= level_index(chan_i ? head.right : head.left);
    end
    if (state == B_ROM) begin
      rom_q <= LIT_ROM[idx_q];
    end
    if (state == B_SCALE) begin
      lit_cnt[chan_i] <= CNT_W'(scaled >> 16);
      chan_i          <= 1'b1;
      iss_chan        <= 1'b0;
      iss_seg         <= '0;
      af              <= 1'b1;
    end
    if (issue) begin
      if (seg_last) begin
        iss_chan <= 1'b1;
        iss_seg  <= '0;
      end else begin
        iss_seg  <= iss_seg + SEG_W'(1);
      end
    end
    if (advance) begin
      s1_chan <= iss_chan;
      s1_seg  <= iss_seg;
      s1_last <= seg_last && iss_chan;
    end
    if (wr) begin
      af        <= af_new;
      channel   <= s1_chan;
      segment   <= s1_seg;
      lit       <= s1_lit;
      fade_step <= s1_lit ? '0 : cur_cnt;
      all_faded <= s1_last && af_new;
      last      <= s1_last;
    end
  end

  // fade counter memory
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_q   <= fade_mem[{iss_chan, iss_seg}];
      rd_vld <= fvalid[{iss_chan, iss_seg}];
    end
    if (wr) begin
      fade_mem[{s1_chan, s1_seg}] <= new_cnt;
    end
  end

  a_lit_no_fade: assert property (@(posedge clk) disable iff (rst)
    out_valid && lit |-> fade_step == '0) else $error("lit segment with fade count");

  a_faded_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && all_faded |-> last) else $error("all_faded off the last result");

  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> CNT_W'(segment) < n_eff) else $error("segment beyond bar length");

  a_pipe_in_walk: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> state == B_WALK) else $error("read stage busy outside walk");

endmodule
`default_nettype wire

[rtl/stereo_bar_meter_with_fade.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_bar_meter_with_fade
// Two-channel bar-graph meter with per-segment fade.
// ----------------------------------------------------------------------------
// Each input transfer (level load or 2 dB decay tick) renders one frame of
// 2*n results, n the segment count in use, left bar first. A frame first
// picks up the queued levels, then does the index, table lookup and
// scaling of both channels in turn, fills the fade counter read stage,
// then gives one segment per cycle while the output is not stalled. A
// two-entry queue takes new items while a frame renders. No clearing
// pass after reset: counters read as zero until first written, and
// writing num_segments clears them at once.
// ----------------------------------------------------------------------------
module stereo_bar_meter_with_fade (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sbm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sbm_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  opcode,
  input  logic signed [sbm_pkg::LEVEL_W-1:0]    level_left,
  input  logic signed [sbm_pkg::LEVEL_W-1:0]    level_right,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  channel,
  output logic [sbm_pkg::SEG_W-1:0]             segment,
  output logic                                  lit,
  output logic [sbm_pkg::FADE_W-1:0]            fade_step,
  output logic                                  all_faded,
  output logic                                  last
);
  import sbm_pkg::*;

  cfg_wr_t     cfg;
  q_stat_t     q_stat;
  level_pair_t push_data;
  level_pair_t head;
  logic        push;
  logic        pop;

  assign cfg_ready = 1'b1;
  assign cfg.en    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  sbm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .level_left  (level_left),
    .level_right (level_right),
    .q_stat      (q_stat),
    .push        (push),
    .push_data   (push_data)
  );

  sbm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  sbm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .channel   (channel),
    .segment   (segment),
    .lit       (lit),
    .fade_step (fade_step),
    .all_faded (all_faded),
    .last      (last)
  );

endmodule
`default_nettype wire

[sim/bar_meter_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bar_meter_checker
// Watches the register, level and segment channels of the stereo bar meter,
// predicts every segment result of each frame from its own copy of the levels,
// fade counters and registers, and compares the results in order, field by
// field. Hands the mismatch count and the number of results still due to the
// testbench top.
// ----------------------------------------------------------------------------
module bar_meter_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [sbm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sbm_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic                                  opcode,
  input  logic signed [sbm_pkg::LEVEL_W-1:0]    level_left,
  input  logic signed [sbm_pkg::LEVEL_W-1:0]    level_right,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic                                  channel,
  input  logic [sbm_pkg::SEG_W-1:0]             segment,
  input  logic                                  lit,
  input  logic [sbm_pkg::FADE_W-1:0]            fade_step,
  input  logic                                  all_faded,
  input  logic                                  last,
  output int                                    mismatches,
  output int                                    pending
);
  import sbm_pkg::*;

  localparam int          FLOOR_Q88    = -10214;
  localparam int          DECAY_Q88    = 512;
  localparam int          MIN_Q88      = -32768;
  localparam logic [95:0] EXP_STEP_Q32 = 96'd4252231657;

  typedef struct packed {
    logic              channel;
    logic [SEG_W-1:0]  segment;
    logic              lit;
    logic [FADE_W-1:0] fade_step;
    logic              all_faded;
    logic              last;
  } seg_result_t;

  int                lit_frac [TABLE_DEPTH];
  int                bar_level [2];
  logic [FADE_W-1:0] fade_cnt [2*MAX_SEGMENTS];
  logic [NSEG_W-1:0] seg_cfg;
  logic [FADE_W-1:0] fade_cfg;
  seg_result_t       frame_q [$];
  int                result_no;

  initial begin
    logic [95:0] acc;
    acc = 96'd1 << 32;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      lit_frac[i] = int'((acc + 96'd32768) >> 16);
      acc = (acc * EXP_STEP_Q32 + (96'd1 << 31)) >> 32;
    end
    mismatches = 0;
    pending    = 0;
    result_no  = 0;
  end

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch at result %0d: %s got %0d, want %0d", result_no, what, got, want);
    mismatches++;
  endtask

  task automatic render_frame(logic is_decay, logic signed [LEVEL_W-1:0] l,
                              logic signed [LEVEL_W-1:0] r);
    int          n, lit_n, zeros, lv, prod, idx, a;
    logic [FADE_W-1:0] reload;
    seg_result_t res;
    if (!is_decay) begin
      bar_level[0] = l;
      bar_level[1] = r;
    end else begin
      for (int c = 0; c < 2; c++) begin
        lv = bar_level[c] - DECAY_Q88;
        bar_level[c] = (lv < MIN_Q88) ? MIN_Q88 : lv;
      end
    end
    n = seg_cfg;
    if (n < 1) n = 1;
    if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
    reload = (fade_cfg == 0) ? '0 : fade_cfg - 1'b1;
    zeros  = 0;
    for (int c = 0; c < 2; c++) begin
      lv   = (bar_level[c] < FLOOR_Q88) ? FLOOR_Q88 : bar_level[c];
      prod = -lv * 15;
      idx  = (prod > 0) ? (prod >> 8) : 0;
      if (idx > TABLE_DEPTH - 1) idx = TABLE_DEPTH - 1;
      lit_n = (n * lit_frac[idx]) >> 16;
      for (int s = 0; s < n; s++) begin
        a = c * MAX_SEGMENTS + s;
        res.channel = c[0];
        res.segment = SEG_W'(s);
        if (s < lit_n) begin
          fade_cnt[a]   = reload;
          res.lit       = 1'b1;
          res.fade_step = '0;
        end else begin
          res.lit       = 1'b0;
          res.fade_step = fade_cnt[a];
          if (fade_cnt[a] != 0) fade_cnt[a] = fade_cnt[a] - 1'b1;
          if (fade_cnt[a] == 0) zeros++;
        end
        res.all_faded = 1'b0;
        res.last      = 1'b0;
        if (c == 1 && s == n - 1) begin
          res.last      = 1'b1;
          res.all_faded = (zeros == 2 * n);
        end
        frame_q.push_back(res);
      end
    end
  endtask

  always @(posedge clk) begin
    seg_result_t got, want;
    if (rst) begin
      seg_cfg      = NSEG_W'(16);
      fade_cfg     = FADE_W'(10);
      bar_level[0] = 0;
      bar_level[1] = 0;
      for (int i = 0; i < 2 * MAX_SEGMENTS; i++) fade_cnt[i] = '0;
      frame_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {channel, segment, lit, fade_step, all_faded, last};
        if (frame_q.size() == 0) begin
          flag_mismatch("result with nothing due, segment", got.segment, 0);
        end else begin
          want = frame_q.pop_front();
          if (got.channel !== want.channel)
            flag_mismatch("channel", got.channel, want.channel);
          if (got.segment !== want.segment)
            flag_mismatch("segment", got.segment, want.segment);
          if (got.lit !== want.lit)
            flag_mismatch("lit", got.lit, want.lit);
          if (got.fade_step !== want.fade_step)
            flag_mismatch("fade_step", got.fade_step, want.fade_step);
          if (got.all_faded !== want.all_faded)
            flag_mismatch("all_faded", got.all_faded, want.all_faded);
          if (got.last !== want.last)
            flag_mismatch("last", got.last, want.last);
        end
        result_no++;
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_NUM_SEGMENTS: begin
            seg_cfg = cfg_data[NSEG_W-1:0];
            for (int i = 0; i < 2 * MAX_SEGMENTS; i++) fade_cnt[i] = '0;
          end
          REG_FADE_STEPS: begin
            fade_cfg = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        render_frame(opcode_t'(opcode) == OP_DECAY, level_left, level_right);
      end
    end
    pending = frame_q.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the stereo bar meter. Runs a short directed set of
// level loads and decay ticks under the reset registers, then phases of random
// loads, decay runs and fade-out sequences under several segment counts and
// fade lengths, with random gaps on the level and segment channels.
// ----------------------------------------------------------------------------
module testbench;
  import sbm_pkg::*;

  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 4_000_000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 49;
  localparam int TAIL_CYCLES     = 80;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      cfg_valid   = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index   = '0;
  logic [CFG_DATA_W-1:0]     cfg_data    = '0;
  logic                      in_valid    = 1'b0;
  logic                      in_ready;
  logic                      opcode      = 1'b0;
  logic signed [LEVEL_W-1:0] level_left  = '0;
  logic signed [LEVEL_W-1:0] level_right = '0;
  logic                      out_valid;
  logic                      out_ready   = 1'b0;
  logic                      channel;
  logic [SEG_W-1:0]          segment;
  logic                      lit;
  logic [FADE_W-1:0]         fade_step;
  logic                      all_faded;
  logic                      last;

  int   fail_count;
  int   pending;
  int   cycles     = 0;
  int   stall_left = 0;
  logic calm       = 1'b0;

  always #(HALF_PERIOD) clk = ~clk;

  stereo_bar_meter_with_fade dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .opcode, .level_left, .level_right,
    .out_valid, .out_ready, .channel, .segment, .lit, .fade_step,
    .all_faded, .last
  );

  bar_meter_checker chk (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .opcode, .level_left, .level_right,
    .out_valid, .out_ready, .channel, .segment, .lit, .fade_step,
    .all_faded, .last,
    .mismatches(fail_count),
    .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int idle_gap();
    if (calm) return 0;
    if ($urandom_range(0, 99) < 25) return gap_len();
    return 0;
  endfunction

  function automatic logic signed [LEVEL_W-1:0] rand_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return LEVEL_W'($urandom);
    if (r < 24) return LEVEL_W'(-10214 + int'($urandom_range(0, 40)) - 20);
    if (r < 34) return LEVEL_W'($urandom_range(0, 32767));
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0:       return 16'sh8000;
        1:       return 16'sh7fff;
        2:       return 16'sh0000;
        default: return 16'shffff;
      endcase
    end
    return LEVEL_W'(-int'($urandom_range(0, 10300)));
  endfunction

  // hold stalls on the result side
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 12) begin
      stall_left <= gap_len() - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(opcode_t op, logic signed [LEVEL_W-1:0] l,
                           logic signed [LEVEL_W-1:0] r);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    opcode      <= op;
    level_left  <= l;
    level_right <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait for every result due
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int count);
    int sent, pick, k;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        drain();
      end else if (pick < 12) begin
        // quiet the bar, then let it fade
        send_item(OP_LOAD, LEVEL_W'(-int'($urandom_range(9000, 32768))),
                  LEVEL_W'(-int'($urandom_range(9000, 32768))));
        k = $urandom_range(2, 12);
        repeat (k) send_item(OP_DECAY, rand_level(), rand_level());
        sent += k + 1;
      end else if (pick < 40) begin
        send_item(OP_DECAY, rand_level(), rand_level());
        sent++;
      end else begin
        send_item(OP_LOAD, rand_level(), rand_level());
        sent++;
      end
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] seg_vals [PHASES];
    logic [CFG_DATA_W-1:0] fade_vals [PHASES];
    seg_vals  = '{8'd1, 8'd32, 8'd0, 8'd0, 8'd63, 8'he1, 8'd5, 8'd0};
    fade_vals = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd128, 8'd7, 8'd3, 8'd0};
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    send_item(OP_LOAD, 16'sh0000, 16'sh0000);
    send_item(OP_LOAD, 16'sh7fff, 16'sh7fff);
    send_item(OP_LOAD, 16'sh8000, 16'sh8000);
    send_item(OP_LOAD, -16'sd10214, -16'sd10213);
    send_item(OP_LOAD, -16'sd10215, -16'sd17);
    send_item(OP_LOAD, -16'sd18, -16'sd256);
    send_item(OP_LOAD, -16'sd1, 16'sd1);
    send_item(OP_LOAD, 16'sh5555, 16'shaaaa);
    send_item(OP_DECAY, 16'sh0000, 16'sh0000);
    send_item(OP_LOAD, -16'sd32767, 16'sh8000);
    repeat (11) send_item(OP_DECAY, 16'shffff, 16'shffff);
    send_item(OP_LOAD, -16'sd3000, -16'sd6000);
    send_item(OP_DECAY, 16'sh1234, 16'shedcb);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      calm = (p == 2);
      if (p == PHASES - 1) begin
        seg_vals[p]  = CFG_DATA_W'($urandom);
        fade_vals[p] = CFG_DATA_W'($urandom);
      end
      write_reg(REG_FADE_STEPS, fade_vals[p]);
      if (p[0]) write_reg(p[1] ? REG_SPARE_3 : REG_SPARE_2, CFG_DATA_W'($urandom));
      // keep counters across this phase
      if (p != 3) write_reg(REG_NUM_SEGMENTS, seg_vals[p]);
      run_random(ITEMS_PER_PHASE);
      drain();
    end

    calm = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
